FILE: hw/rtl/c8_pkg.sv
// ----------------------------------------------------------------------------
// c8_pkg
// Shared types, sizes and decode helpers of the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package c8_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int STACK_DEPTH = 16;
    localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int KEY_WINDOW  = 10;
    localparam int KW_AW       = (KEY_WINDOW > 1) ? $clog2(KEY_WINDOW) : 1;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;

    localparam logic [11:0] START_RESET = 12'd512;
    localparam logic [3:0]  BCD_LAST    = 4'd2;

    localparam logic [15:0] OP_CLS = 16'h00e0;
    localparam logic [15:0] OP_RET = 16'h00ee;

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEI  = 4'h3;
    localparam logic [3:0] OP_SNEI = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDIX = 4'ha;
    localparam logic [3:0] OP_JPV0 = 4'hb;
    localparam logic [3:0] OP_RND  = 4'hc;
    localparam logic [3:0] OP_DRW  = 4'hd;
    localparam logic [3:0] OP_KEY  = 4'he;
    localparam logic [3:0] OP_MISC = 4'hf;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'he;

    localparam logic [7:0] KK_SKP  = 8'h9e;
    localparam logic [7:0] KK_SKNP = 8'ha1;
    localparam logic [7:0] KK_GDT  = 8'h07;
    localparam logic [7:0] KK_WKEY = 8'h0a;
    localparam logic [7:0] KK_SDT  = 8'h15;
    localparam logic [7:0] KK_SST  = 8'h18;
    localparam logic [7:0] KK_ADDI = 8'h1e;
    localparam logic [7:0] KK_FONT = 8'h29;
    localparam logic [7:0] KK_BCD  = 8'h33;
    localparam logic [7:0] KK_SAVE = 8'h55;
    localparam logic [7:0] KK_REST = 8'h65;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    typedef enum logic [2:0] {
        REQ_LOAD, REQ_EXEC, REQ_TICK, REQ_KEYS, REQ_COLL
    } req_t;

    typedef enum logic [2:0] {
        MEM_NONE, MEM_RD_PC, MEM_RD_PC1, MEM_RD_IK,
        MEM_WR_LOAD, MEM_WR_BCD, MEM_WR_REG
    } mem_op_t;

    typedef enum logic [1:0] {RSEL_X, RSEL_Y, RSEL_K} rsel_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SIMPLE, S_FETCH_HI, S_FETCH_LO, S_WAIT_LO,
        S_READ_X, S_READ_Y, S_EXEC, S_ROW_ADDR, S_ROW_PUSH, S_BCD,
        S_SAVE, S_LOAD_ADDR, S_LOAD_DATA, S_FINISH
    } state_t;

    typedef struct packed {
        logic    accept;
        mem_op_t mem_op;
        rsel_t   rsel;
        logic    lat_hi;
        logic    lat_lo;
        logic    lat_vx;
        logic    lat_vy;
        logic    exec;
        logic    simple;
        logic    push_row;
        logic    load_reg;
        logic    k_clr;
        logic    k_inc;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic [3:0] op_hi;
        logic [3:0] x;
        logic [3:0] n;
        logic [7:0] kk;
        logic [3:0] k;
        logic       halted;
        logic       can_push;
    } stat_t;

    function automatic logic is_row(logic [3:0] hi, logic [3:0] n);
        return (hi == OP_DRW) && (n != 4'd0);
    endfunction

    function automatic logic is_walk(logic [3:0] hi, logic [7:0] kk);
        return (hi == OP_MISC) && ((kk == KK_BCD) || (kk == KK_SAVE) || (kk == KK_REST));
    endfunction

endpackage

FILE: hw/rtl/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 instruction core: byte loads, execution, timers, keys, sprite rows.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (kind in s_tuser), results leave on m_
// (m_tuser flags a sprite row, m_tlast marks the last result of a request).
// cfg_valid/cfg_data write the start address, which also reloads pc; write it
// only while the core is idle.
// One request is worked at a time. Load, tick, key sample and collision
// requests pass from dispatch to a single result step. An execute makes
// two fetch reads through the single-port program memory, two register-file
// reads and one execute step. Dxyn adds a memory read and a result per row,
// Fx33 writes three digits, Fx55 writes V0..Vx and Fx65 reads V0..Vx back.
// The result register frees the result side: a new request is accepted while
// a result waits; work stalls only when a further result must be written.
// Reset clears all control state, registers, timers and the key ring; pc
// returns to 0x200. Program memory is not cleared.
// ----------------------------------------------------------------------------
module chip8_instruction_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // mem_address[11:0], mem_data[19:12], key_bits[35:20],
    // random_value[43:36], collision_flag[44]
    input  logic [c8_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type[2:0]
    input  logic [2:0]                    s_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [11:0]                   cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pc_value[15:0], status[17:16], clear_request[18], sprite_x[26:19],
    // sprite_y[34:27], row_index[38:35], row_bits[46:39], row_count[50:47],
    // sound_on[51]
    output logic [c8_pkg::M_DATA_W-1:0]   m_tdata,
    // row_valid[0]
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import c8_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    c8_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    c8_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );
endmodule

FILE: hw/rtl/c8_ram.sv
// ----------------------------------------------------------------------------
// c8_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: hw/rtl/c8_ctrl.sv
// ----------------------------------------------------------------------------
// c8_ctrl
// Sequencer: accepts requests, walks fetch, decode and multi-cycle steps.
// ----------------------------------------------------------------------------
module c8_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  c8_pkg::stat_t  stat,
    output c8_pkg::cmd_t   cmd
);
    import c8_pkg::*;

    state_t state_reg, state_next;
    logic   row_last;

    assign row_last = (stat.k == stat.n - 4'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (stat.req == REQ_EXEC && !stat.halted) state_next = S_FETCH_HI;
                else state_next = S_SIMPLE;
            end
            S_SIMPLE: begin
                if (stat.can_push) state_next = S_IDLE;
            end
            S_FETCH_HI: state_next = S_FETCH_LO;
            S_FETCH_LO: state_next = S_WAIT_LO;
            S_WAIT_LO:  state_next = S_READ_X;
            S_READ_X:   state_next = S_READ_Y;
            S_READ_Y:   state_next = S_EXEC;
            S_EXEC: begin
                if (is_row(stat.op_hi, stat.n)) begin
                    state_next = S_ROW_ADDR;
                end else if (is_walk(stat.op_hi, stat.kk)) begin
                    case (stat.kk)
                        KK_BCD:  state_next = S_BCD;
                        KK_SAVE: state_next = S_SAVE;
                        default: state_next = S_LOAD_ADDR;
                    endcase
                end else if (stat.can_push) begin
                    state_next = S_IDLE;
                end
            end
            S_ROW_ADDR: state_next = S_ROW_PUSH;
            S_ROW_PUSH: begin
                if (stat.can_push) state_next = row_last ? S_IDLE : S_ROW_ADDR;
            end
            S_BCD: begin
                if (stat.k == BCD_LAST) state_next = S_FINISH;
            end
            S_SAVE: begin
                if (stat.k == stat.x) state_next = S_FINISH;
            end
            S_LOAD_ADDR: state_next = S_LOAD_DATA;
            S_LOAD_DATA: state_next = (stat.k == stat.x) ? S_FINISH : S_LOAD_ADDR;
            S_FINISH: begin
                if (stat.can_push) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.mem_op = MEM_NONE;
        cmd.rsel   = RSEL_X;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            S_SIMPLE: begin
                if (stat.can_push) begin
                    cmd.simple = 1'b1;
                    if (stat.req == REQ_LOAD) cmd.mem_op = MEM_WR_LOAD;
                end
            end
            S_FETCH_HI: cmd.mem_op = MEM_RD_PC;
            S_FETCH_LO: begin
                cmd.lat_hi = 1'b1;
                cmd.mem_op = MEM_RD_PC1;
            end
            S_WAIT_LO: cmd.lat_lo = 1'b1;
            S_READ_X: begin
                cmd.rsel   = RSEL_X;
                cmd.lat_vx = 1'b1;
            end
            S_READ_Y: begin
                cmd.rsel   = RSEL_Y;
                cmd.lat_vy = 1'b1;
            end
            S_EXEC: begin
                if (is_row(stat.op_hi, stat.n) || is_walk(stat.op_hi, stat.kk) ||
                    stat.can_push) begin
                    cmd.exec  = 1'b1;
                    cmd.k_clr = 1'b1;
                end
            end
            S_ROW_ADDR: cmd.mem_op = MEM_RD_IK;
            S_ROW_PUSH: begin
                if (stat.can_push) begin
                    cmd.push_row = 1'b1;
                    cmd.k_inc    = 1'b1;
                end
            end
            S_BCD: begin
                cmd.mem_op = MEM_WR_BCD;
                cmd.k_inc  = 1'b1;
            end
            S_SAVE: begin
                cmd.rsel   = RSEL_K;
                cmd.mem_op = MEM_WR_REG;
                cmd.k_inc  = 1'b1;
            end
            S_LOAD_ADDR: cmd.mem_op = MEM_RD_IK;
            S_LOAD_DATA: begin
                cmd.load_reg = 1'b1;
                cmd.k_inc    = 1'b1;
            end
            S_FINISH: cmd.finish = stat.can_push;
            default: cmd = '0;
        endcase
    end
endmodule

FILE: hw/rtl/c8_dp.sv
// ----------------------------------------------------------------------------
// c8_dp
// Datapath: architectural state, instruction execution, memory, result register.
// ----------------------------------------------------------------------------
module c8_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  c8_pkg::cmd_t                  cmd,
    output c8_pkg::stat_t                 stat,
    input  logic [c8_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [2:0]                    s_tuser,
    input  logic                          cfg_we,
    input  logic [11:0]                   cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [c8_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import c8_pkg::*;

    // state
    logic [11:0]        start_reg;
    logic [15:0]        pc_reg, i_reg;
    logic [7:0]         v_reg [16];
    logic [15:0]        stack_reg [STACK_DEPTH];
    logic [DEPTH_W-1:0] depth_reg;
    logic [7:0]         delay_reg, sound_reg;
    logic [15:0]        hist_reg [KEY_WINDOW];
    logic [KW_AW-1:0]   slot_reg;
    logic [15:0]        latest_reg;
    logic               halted_reg;
    logic [3:0]         k_reg;

    // request and operands
    logic [2:0]          req_reg;
    logic [S_DATA_W-1:0] in_reg;
    logic [7:0]          op_hi_reg, op_lo_reg;
    logic [7:0]          vx_reg, vy_reg;

    // result register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_user_reg, out_last_reg;

    logic [11:0] in_addr;
    logic [7:0]  in_mdata, in_rnd;
    logic [15:0] in_keys;
    logic        in_coll;
    assign in_addr  = in_reg[11:0];
    assign in_mdata = in_reg[19:12];
    assign in_keys  = in_reg[35:20];
    assign in_rnd   = in_reg[43:36];
    assign in_coll  = in_reg[44];

    logic [15:0] op;
    logic [3:0]  op_x, op_y, op_n, op_top;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn;
    assign op     = {op_hi_reg, op_lo_reg};
    assign op_top = op[15:12];
    assign op_x   = op[11:8];
    assign op_y   = op[7:4];
    assign op_n   = op[3:0];
    assign op_kk  = op[7:0];
    assign op_nnn = op[11:0];

    logic can_push;
    assign can_push = !out_valid_reg || m_tready;

    assign stat.req      = req_reg;
    assign stat.op_hi    = op_top;
    assign stat.x        = op_x;
    assign stat.n        = op_n;
    assign stat.kk       = op_kk;
    assign stat.k        = k_reg;
    assign stat.halted   = halted_reg;
    assign stat.can_push = can_push;

    // register file read port
    logic [3:0] rd_idx;
    logic [7:0] rd_data;
    always_comb begin
        case (cmd.rsel)
            RSEL_X:  rd_idx = op_x;
            RSEL_Y:  rd_idx = op_y;
            RSEL_K:  rd_idx = k_reg;
            default: rd_idx = op_x;
        endcase
    end
    assign rd_data = v_reg[rd_idx];

    // BCD digits
    logic [7:0]  bcd_h, bcd_r, bcd_t, bcd_o, bcd_digit;
    logic [15:0] bcd_prod;
    always_comb begin
        if (vx_reg >= 8'd200)      bcd_h = 8'd2;
        else if (vx_reg >= 8'd100) bcd_h = 8'd1;
        else                       bcd_h = 8'd0;
        bcd_r    = 8'(vx_reg - bcd_h * 8'd100);
        bcd_prod = {8'd0, bcd_r} * 16'd205;
        bcd_t    = 8'(bcd_prod >> 11);
        bcd_o    = 8'(bcd_r - bcd_t * 8'd10);
        case (k_reg)
            4'd0:    bcd_digit = bcd_h;
            4'd1:    bcd_digit = bcd_t;
            default: bcd_digit = bcd_o;
        endcase
    end

    // memory port
    logic [15:0]       pc_inc, ik_addr;
    logic              ram_en, ram_we;
    logic [MEM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;
    assign pc_inc  = pc_reg + 16'd1;
    assign ik_addr = i_reg + {12'd0, k_reg};

    always_comb begin
        ram_en    = 1'b1;
        ram_we    = 1'b0;
        ram_addr  = pc_reg[MEM_AW-1:0];
        ram_wdata = in_mdata;
        case (cmd.mem_op)
            MEM_RD_PC:   ram_addr = pc_reg[MEM_AW-1:0];
            MEM_RD_PC1:  ram_addr = pc_inc[MEM_AW-1:0];
            MEM_RD_IK:   ram_addr = ik_addr[MEM_AW-1:0];
            MEM_WR_LOAD: begin
                ram_we   = 1'b1;
                ram_addr = MEM_AW'(in_addr);
            end
            MEM_WR_BCD: begin
                ram_we    = 1'b1;
                ram_addr  = ik_addr[MEM_AW-1:0];
                ram_wdata = bcd_digit;
            end
            MEM_WR_REG: begin
                ram_we    = 1'b1;
                ram_addr  = ik_addr[MEM_AW-1:0];
                ram_wdata = rd_data;
            end
            default: ram_en = 1'b0;
        endcase
    end

    c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // key ring
    logic [15:0] ring_or;
    logic [3:0]  top_key;
    always_comb begin
        ring_or = '0;
        for (int i = 0; i < KEY_WINDOW; i++) ring_or |= hist_reg[i];
        top_key = '0;
        for (int i = 0; i < 16; i++) begin
            if (latest_reg[i]) top_key = 4'(i);
        end
    end

    // execute
    logic [15:0] pc_next_e, i_next_e, pc_two;
    logic        vx_we, vf_we, halt_set, wait_key, clr_e, push_e;
    logic        stk_push, stk_pop, dly_we, snd_we, key_clr_bit, key_clr_all;
    logic [7:0]  vx_wd, vf_wd;
    logic [8:0]  sum9;
    logic        skip_eq, key_down;
    assign pc_two = pc_reg + 16'd2;
    assign sum9   = {1'b0, vx_reg} + {1'b0, vy_reg};

    always_comb begin
        pc_next_e   = pc_two;
        i_next_e    = i_reg;
        vx_we       = 1'b0;
        vx_wd       = '0;
        vf_we       = 1'b0;
        vf_wd       = '0;
        halt_set    = 1'b0;
        wait_key    = 1'b0;
        clr_e       = 1'b0;
        stk_push    = 1'b0;
        stk_pop     = 1'b0;
        dly_we      = 1'b0;
        snd_we      = 1'b0;
        key_clr_bit = 1'b0;
        key_clr_all = 1'b0;
        push_e      = !(is_row(op_top, op_n) || is_walk(op_top, op_kk));
        skip_eq     = 1'b0;
        key_down    = ring_or[vx_reg[3:0]];
        if (op == OP_CLS) begin
            clr_e = 1'b1;
        end else if (op == OP_RET) begin
            if (depth_reg != '0) begin
                stk_pop   = 1'b1;
                pc_next_e = stack_reg[STK_AW'(depth_reg - DEPTH_W'(1))];
            end else begin
                halt_set = 1'b1;
            end
        end else begin
            case (op_top)
                OP_SYS, OP_JP: pc_next_e = {4'd0, op_nnn};
                OP_CALL: begin
                    if (depth_reg < DEPTH_W'(STACK_DEPTH)) begin
                        stk_push  = 1'b1;
                        pc_next_e = {4'd0, op_nnn};
                    end else begin
                        halt_set = 1'b1;
                    end
                end
                OP_SEI, OP_SNEI, OP_SER, OP_SNER: begin
                    skip_eq = (op_top == OP_SEI || op_top == OP_SNEI) ?
                              (vx_reg == op_kk) : (vx_reg == vy_reg);
                    if ((op_top == OP_SEI || op_top == OP_SER) ? skip_eq : !skip_eq)
                        pc_next_e = pc_reg + 16'd4;
                end
                OP_LDI: begin
                    vx_we = 1'b1;
                    vx_wd = op_kk;
                end
                OP_ADDI: begin
                    vx_we = 1'b1;
                    vx_wd = vx_reg + op_kk;
                end
                OP_ALU: begin
                    vx_we = 1'b1;
                    vf_we = 1'b1;
                    case (op_n)
                        ALU_MOV: begin vx_wd = vy_reg; vf_we = 1'b0; end
                        ALU_OR:  begin vx_wd = vx_reg | vy_reg; vf_we = 1'b0; end
                        ALU_AND: begin vx_wd = vx_reg & vy_reg; vf_we = 1'b0; end
                        ALU_XOR: begin vx_wd = vx_reg ^ vy_reg; vf_we = 1'b0; end
                        ALU_ADD: begin vx_wd = sum9[7:0]; vf_wd = {7'd0, sum9[8]}; end
                        ALU_SUB: begin
                            vx_wd = vx_reg - vy_reg;
                            vf_wd = {7'd0, vx_reg >= vy_reg};
                        end
                        ALU_SHR: begin vx_wd = vx_reg >> 1; vf_wd = {7'd0, vx_reg[0]}; end
                        ALU_SBN: begin
                            vx_wd = vy_reg - vx_reg;
                            vf_wd = {7'd0, vy_reg >= vx_reg};
                        end
                        ALU_SHL: begin vx_wd = vx_reg << 1; vf_wd = {7'd0, vx_reg[7]}; end
                        default: begin
                            vx_we     = 1'b0;
                            vf_we     = 1'b0;
                            halt_set  = 1'b1;
                            pc_next_e = pc_reg;
                        end
                    endcase
                end
                OP_LDIX: i_next_e = {4'd0, op_nnn};
                OP_JPV0: pc_next_e = {4'd0, op_nnn} + {8'd0, v_reg[0]};
                OP_RND: begin
                    vx_we = 1'b1;
                    vx_wd = in_rnd & op_kk;
                end
                OP_DRW: pc_next_e = pc_two;
                OP_KEY: begin
                    if (op_kk == KK_SKP || op_kk == KK_SKNP) begin
                        if (key_down != (op_kk == KK_SKNP)) begin
                            key_clr_bit = 1'b1;
                            pc_next_e   = pc_reg + 16'd4;
                        end
                    end else begin
                        halt_set  = 1'b1;
                        pc_next_e = pc_reg;
                    end
                end
                default: begin
                    case (op_kk)
                        KK_GDT: begin vx_we = 1'b1; vx_wd = delay_reg; end
                        KK_WKEY: begin
                            if (latest_reg == '0) begin
                                wait_key  = 1'b1;
                                pc_next_e = pc_reg;
                            end else begin
                                vx_we       = 1'b1;
                                vx_wd       = {4'd0, top_key};
                                key_clr_all = 1'b1;
                            end
                        end
                        KK_SDT:  dly_we = 1'b1;
                        KK_SST:  snd_we = 1'b1;
                        KK_ADDI: i_next_e = i_reg + {8'd0, vx_reg};
                        KK_FONT: i_next_e = {8'd0, vx_reg} * 16'd5;
                        KK_BCD, KK_SAVE, KK_REST: pc_next_e = pc_reg;
                        default: begin
                            halt_set  = 1'b1;
                            pc_next_e = pc_reg;
                        end
                    endcase
                end
            endcase
        end
        if (halt_set) pc_next_e = pc_reg;
    end

    // result assembly
    logic       push_en, p_clr, p_row, p_last, p_sound;
    logic [1:0] p_status;
    logic [15:0] p_pc;
    logic [7:0] p_sx, p_sy, p_bits, snd_after;
    logic [3:0] p_idx, p_cnt;
    always_comb begin
        push_en   = 1'b0;
        p_clr     = 1'b0;
        p_row     = 1'b0;
        p_last    = 1'b1;
        p_status  = halted_reg ? ST_HALT : ST_OK;
        p_pc      = pc_reg;
        p_sx      = '0;
        p_sy      = '0;
        p_bits    = '0;
        p_idx     = '0;
        p_cnt     = '0;
        snd_after = sound_reg;
        if (cmd.simple) begin
            push_en = 1'b1;
            if (req_reg == REQ_TICK && sound_reg != '0) snd_after = sound_reg - 8'd1;
        end else if (cmd.exec) begin
            push_en  = push_e;
            p_clr    = clr_e;
            p_pc     = pc_next_e;
            p_status = halt_set ? ST_HALT : (wait_key ? ST_WAIT : ST_OK);
            if (snd_we) snd_after = vx_reg;
        end else if (cmd.push_row) begin
            push_en = 1'b1;
            p_row   = 1'b1;
            p_sx    = vx_reg;
            p_sy    = vy_reg;
            p_idx   = k_reg;
            p_bits  = ram_rdata;
            p_cnt   = op_n;
            p_last  = (k_reg == op_n - 4'd1);
        end else if (cmd.finish) begin
            push_en  = 1'b1;
            p_pc     = pc_two;
            p_status = ST_OK;
        end
        p_sound = (snd_after != '0);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg     <= START_RESET;
            pc_reg        <= {4'd0, START_RESET};
            i_reg         <= '0;
            depth_reg     <= '0;
            delay_reg     <= '0;
            sound_reg     <= '0;
            slot_reg      <= '0;
            latest_reg    <= '0;
            halted_reg    <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++) v_reg[i] <= '0;
            for (int i = 0; i < KEY_WINDOW; i++) hist_reg[i] <= '0;
        end else begin
            if (cfg_we) begin
                start_reg <= cfg_data;
                pc_reg    <= {4'd0, cfg_data};
            end
            if (push_en) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;

            if (cmd.k_clr) k_reg <= '0;
            else if (cmd.k_inc) k_reg <= k_reg + 4'd1;

            if (cmd.lat_vx) vx_reg <= rd_data;
            if (cmd.load_reg) v_reg[k_reg] <= ram_rdata;

            if (cmd.simple) begin
                case (req_reg)
                    REQ_TICK: begin
                        if (delay_reg != '0) delay_reg <= delay_reg - 8'd1;
                        if (sound_reg != '0) sound_reg <= sound_reg - 8'd1;
                    end
                    REQ_KEYS: begin
                        latest_reg         <= in_keys;
                        hist_reg[slot_reg] <= in_keys;
                        slot_reg <= (slot_reg == KW_AW'(KEY_WINDOW - 1)) ?
                                    '0 : slot_reg + KW_AW'(1);
                    end
                    REQ_COLL: v_reg[15] <= {7'd0, in_coll};
                    default: ;
                endcase
            end
            if (cmd.exec) begin
                pc_reg <= pc_next_e;
                i_reg  <= i_next_e;
                if (halt_set) halted_reg <= 1'b1;
                if (vx_we) v_reg[op_x] <= vx_wd;
                if (vf_we) v_reg[15] <= vf_wd;
                if (stk_push) depth_reg <= depth_reg + DEPTH_W'(1);
                if (stk_pop) depth_reg <= depth_reg - DEPTH_W'(1);
                if (dly_we) delay_reg <= vx_reg;
                if (snd_we) sound_reg <= vx_reg;
                for (int i = 0; i < KEY_WINDOW; i++) begin
                    if (key_clr_all) hist_reg[i] <= '0;
                    else if (key_clr_bit) hist_reg[i][vx_reg[3:0]] <= 1'b0;
                end
            end
            if (cmd.finish) pc_reg <= pc_two;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg <= s_tuser;
            in_reg  <= s_tdata;
        end
        if (cmd.lat_hi) op_hi_reg <= ram_rdata;
        if (cmd.lat_lo) op_lo_reg <= ram_rdata;
        if (cmd.lat_vy) vy_reg <= rd_data;
        if (cmd.exec && stk_push) stack_reg[STK_AW'(depth_reg)] <= pc_two;
        if (push_en) begin
            out_data_reg <= {4'd0, p_sound, p_cnt, p_bits, p_idx, p_sy, p_sx,
                             p_clr, p_status, p_pc};
            out_user_reg <= p_row;
            out_last_reg <= p_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;
endmodule

FILE: hw/rtl/c8_checker.sv
// ----------------------------------------------------------------------------
// c8_checker
// Port-level checks of the CHIP-8 instruction core, bound to the top level.
// ----------------------------------------------------------------------------
module c8_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [c8_pkg::S_DATA_W-1:0]   s_tdata,
    input logic [2:0]                    s_tuser,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [11:0]                   cfg_data,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [c8_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                          m_tuser,
    input logic                          m_tlast
);
    import c8_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_row_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[17:16] == ST_OK && !m_tdata[18])
        else $error("sprite row with bad status");

    a_no_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[50:19] == '0 && m_tlast)
        else $error("non-row result carries row fields");
endmodule

bind chip8_instruction_core c8_checker u_c8_checker (.*);
